// ===== rtl/pts_pkg.sv =====
`default_nettype none

package pts_pkg;

  // Defaults for the top-level parameters
  localparam int MaxTasksDef = 32;
  localparam int TimeBitsDef = 16;

  // Fixed field widths
  localparam int IdWidth   = 5;
  localparam int PrioWidth = 8;
  localparam int TimeWidth = 16;

  // Tie-break generator: right-shifting Galois LFSR
  localparam int          LfsrWidth = 32;
  localparam logic [31:0] LfsrTaps  = 32'h8020_0003;
  localparam logic [31:0] LfsrOne   = 32'h0000_0001;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic item_en;    // an input transaction is taken this cycle
    logic cfg_we;     // seed write
    logic div_start;  // advance the LFSR and load the remainder unit
    logic div_step;   // one remainder step
    logic rd_en;      // read the tie store
    logic out_load;   // load the result register and clear the round
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic have_best;
    logic multi_tie;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/pts_ram.sv =====
`default_nettype none

module pts_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/pts_ctrl.sv =====
`default_nettype none

module pts_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             is_last_i,
  input  wire logic             cfg_valid_i,
  input  wire pts_pkg::status_t status_i,
  output      logic             in_stall_o,
  output      logic             cfg_ready_o,
  output      pts_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StDecide  = 3'd1;
  localparam logic [2:0] StDivide  = 3'd2;
  localparam logic [2:0] StRead    = 3'd3;
  localparam logic [2:0] StDeliver = 3'd4;

  logic [2:0] state_q, state_d;
  logic       idle;

  assign idle        = (state_q == StIdle);
  assign in_stall_o  = !idle;
  assign cfg_ready_o = idle;

  // Next state and commands
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.item_en   = in_valid_i && idle;
    cmd_o.cfg_we    = cfg_valid_i && idle;
    case (state_q)
      StIdle: begin
        if (in_valid_i && is_last_i) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (!status_i.have_best) begin
          state_d = StDeliver;
        end else if (status_i.multi_tie) begin
          cmd_o.div_start = 1'b1;
          state_d         = StDivide;
        end else begin
          state_d = StRead;
        end
      end
      StDivide: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StDeliver;
      end
      StDeliver: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  // The remainder unit runs only with a real tie
  a_div_needs_tie: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivide) |-> status_i.multi_tie)
    else $error("remainder pass without a tie");

  // The last remainder step hands over to the store read
  a_div_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivide && status_i.div_last) |=> (state_q == StRead))
    else $error("remainder pass did not end in a read");

  // A waiting result keeps the controller in delivery
  a_deliver_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDeliver && !status_i.out_free) |=> (state_q == StDeliver))
    else $error("delivery left while the result was stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/pts_datapath.sv =====
`default_nettype none

module pts_datapath #(
  parameter int MAX_TASKS = pts_pkg::MaxTasksDef,
  parameter int TIME_BITS = pts_pkg::TimeBitsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire pts_pkg::cmd_t                     cmd_i,
  output      pts_pkg::status_t                  status_o,
  input  wire logic                              task_valid_i,
  input  wire logic [pts_pkg::IdWidth-1:0]       task_id_i,
  input  wire logic [pts_pkg::PrioWidth-1:0]     static_priority_i,
  input  wire logic [pts_pkg::TimeWidth-1:0]     arrival_time_i,
  input  wire logic [pts_pkg::TimeWidth-1:0]     total_duration_i,
  input  wire logic                              is_running_i,
  input  wire logic [pts_pkg::LfsrWidth-1:0]     random_seed_i,
  input  wire logic                              out_stall_i,
  output      logic                              out_valid_o,
  output      logic                              selected_valid_o,
  output      logic [pts_pkg::IdWidth-1:0]       selected_id_o,
  output      logic                              won_lottery_o
);

  localparam int CmpBits = (TIME_BITS < pts_pkg::TimeWidth) ? TIME_BITS : pts_pkg::TimeWidth;
  localparam int CW      = $clog2(MAX_TASKS + 1);
  localparam int IW      = $clog2(MAX_TASKS);
  localparam int LW      = pts_pkg::LfsrWidth;
  localparam int SW      = $clog2(pts_pkg::LfsrWidth);

  // Round state
  logic                          have_best_q, have_best_d;
  logic [pts_pkg::PrioWidth-1:0] best_prio_q, best_prio_d;
  logic [CmpBits-1:0]            best_arr_q, best_arr_d;
  logic [CmpBits-1:0]            best_dur_q, best_dur_d;
  logic                          best_run_q, best_run_d;
  logic [CW-1:0]                 tie_count_q, tie_count_d;
  logic [LW-1:0]                 lfsr_q, lfsr_d;

  // Remainder unit
  logic [LW-1:0] dividend_q, dividend_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [SW-1:0] step_q, step_d;

  // Result register
  logic                        out_valid_q, out_valid_d;
  logic                        sel_valid_q;
  logic [pts_pkg::IdWidth-1:0] sel_id_q;
  logic                        won_q;

  logic [CmpBits-1:0]          arr_c, dur_c;
  logic                        beats, ties, store_we;
  logic [IW-1:0]               store_waddr, store_raddr;
  logic [pts_pkg::IdWidth-1:0] store_rdata;
  logic [LW-1:0]               lfsr_next;
  logic [CW:0]                 trial;
  logic                        multi_tie;

  assign arr_c = arrival_time_i[CmpBits-1:0];
  assign dur_c = total_duration_i[CmpBits-1:0];

  // Rank the candidate against the best so far
  always_comb begin
    beats = !have_best_q;
    if (static_priority_i != best_prio_q) begin
      beats = beats || (static_priority_i > best_prio_q);
    end else if (is_running_i != best_run_q) begin
      beats = beats || is_running_i;
    end else if (arr_c != best_arr_q) begin
      beats = beats || (arr_c < best_arr_q);
    end else begin
      beats = beats || (dur_c < best_dur_q);
    end
  end

  assign ties = have_best_q && (static_priority_i == best_prio_q) &&
                (is_running_i == best_run_q) && (arr_c == best_arr_q) &&
                (dur_c == best_dur_q);

  assign multi_tie = (tie_count_q > CW'(1));

  // One Galois step of the tie-break generator
  assign lfsr_next = (lfsr_q >> 1) ^ (lfsr_q[0] ? pts_pkg::LfsrTaps : '0);

  // Tie store access
  assign store_we    = cmd_i.item_en && task_valid_i &&
                       (beats || (ties && (tie_count_q < CW'(MAX_TASKS))));
  assign store_waddr = beats ? IW'(0) : tie_count_q[IW-1:0];
  assign store_raddr = multi_tie ? rem_q[IW-1:0] : IW'(0);

  assign trial = {rem_q, dividend_q[LW-1]};

  // Round, generator, remainder and result updates
  always_comb begin
    have_best_d = have_best_q;
    best_prio_d = best_prio_q;
    best_arr_d  = best_arr_q;
    best_dur_d  = best_dur_q;
    best_run_d  = best_run_q;
    tie_count_d = tie_count_q;
    lfsr_d      = lfsr_q;
    dividend_d  = dividend_q;
    rem_d       = rem_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;

    // Take a candidate
    if (cmd_i.item_en && task_valid_i) begin
      if (beats) begin
        have_best_d = 1'b1;
        best_prio_d = static_priority_i;
        best_arr_d  = arr_c;
        best_dur_d  = dur_c;
        best_run_d  = is_running_i;
        tie_count_d = CW'(1);
      end else if (ties && (tie_count_q < CW'(MAX_TASKS))) begin
        tie_count_d = tie_count_q + CW'(1);
      end
    end

    // Reload the seed, zero maps to one
    if (cmd_i.cfg_we) begin
      lfsr_d = (random_seed_i == '0) ? pts_pkg::LfsrOne : random_seed_i;
    end

    // Advance the generator and start the remainder
    if (cmd_i.div_start) begin
      lfsr_d     = lfsr_next;
      dividend_d = lfsr_next;
      rem_d      = '0;
      step_d     = '0;
    end

    // Restoring remainder, one bit per cycle
    if (cmd_i.div_step) begin
      dividend_d = dividend_q << 1;
      step_d     = step_q + SW'(1);
      if (trial >= {1'b0, tie_count_q}) begin
        rem_d = CW'(trial - {1'b0, tie_count_q});
      end else begin
        rem_d = trial[CW-1:0];
      end
    end

    // Publish the result and clear the round
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      have_best_d = 1'b0;
      tie_count_d = '0;
      best_prio_d = '0;
      best_arr_d  = '0;
      best_dur_d  = '0;
      best_run_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q <= 1'b0;
      tie_count_q <= '0;
      lfsr_q      <= pts_pkg::LfsrOne;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      have_best_q <= have_best_d;
      tie_count_q <= tie_count_d;
      lfsr_q      <= lfsr_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    best_prio_q <= best_prio_d;
    best_arr_q  <= best_arr_d;
    best_dur_q  <= best_dur_d;
    best_run_q  <= best_run_d;
    dividend_q  <= dividend_d;
    rem_q       <= rem_d;
    if (cmd_i.out_load) begin
      sel_valid_q <= have_best_q;
      sel_id_q    <= have_best_q ? store_rdata : '0;
      won_q       <= multi_tie;
    end
  end

  pts_ram #(
    .WIDTH (pts_pkg::IdWidth),
    .DEPTH (MAX_TASKS)
  ) u_tie_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (task_id_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  assign status_o.have_best = have_best_q;
  assign status_o.multi_tie = multi_tie;
  assign status_o.div_last  = (step_q == SW'(LW - 1));
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign selected_valid_o = sel_valid_q;
  assign selected_id_o    = sel_id_q;
  assign won_lottery_o    = won_q;

`ifndef SYNTHESIS
  // The tie count saturates at the store depth
  a_tie_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tie_count_q <= CW'(MAX_TASKS))
    else $error("tie count beyond store depth");

  // A best candidate exists exactly when the store holds an entry
  a_best_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_best_q == (tie_count_q != '0))
    else $error("best flag and tie count disagree");

  // A loaded result is presented in the next cycle and the round is clear
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (out_valid_q && !have_best_q))
    else $error("result load not presented");
`endif

endmodule

`default_nettype wire

// ===== rtl/priority_task_selector_unit.sv =====
`default_nettype none

// Channel   Handshake                   Payload
// input     in_valid_i / in_stall_o     task_valid_i .. is_last_i
// output    out_valid_o / out_stall_i   selected_valid_o, selected_id_o, won_lottery_o
// config    cfg_valid_i / cfg_ready_o   random_seed_i
//
// A candidate transaction is one rank compare and at most one tie store write.
// A closing transaction stalls the input through Decide, Read and Deliver (an empty round
// skips Read); with a tie, Divide runs the 32-step remainder of the LFSR by the tie count first.
// Reset loads the LFSR with 1 and clears the round; the tie store is not cleared.
// A stalled result holds; the next candidates are still taken, the next close waits.

module priority_task_selector_unit #(
  parameter int MAX_TASKS = pts_pkg::MaxTasksDef,
  parameter int TIME_BITS = pts_pkg::TimeBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic                          task_valid_i,
  input  wire logic [pts_pkg::IdWidth-1:0]   task_id_i,
  input  wire logic [pts_pkg::PrioWidth-1:0] static_priority_i,
  input  wire logic [pts_pkg::TimeWidth-1:0] arrival_time_i,
  input  wire logic [pts_pkg::TimeWidth-1:0] total_duration_i,
  input  wire logic                          is_running_i,
  input  wire logic                          is_last_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic                          selected_valid_o,
  output      logic [pts_pkg::IdWidth-1:0]   selected_id_o,
  output      logic                          won_lottery_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [pts_pkg::LfsrWidth-1:0] random_seed_i
);

  pts_pkg::cmd_t    cmd;
  pts_pkg::status_t status;

  pts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .is_last_i   (is_last_i),
    .cfg_valid_i (cfg_valid_i),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  pts_datapath #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .task_valid_i      (task_valid_i),
    .task_id_i         (task_id_i),
    .static_priority_i (static_priority_i),
    .arrival_time_i    (arrival_time_i),
    .total_duration_i  (total_duration_i),
    .is_running_i      (is_running_i),
    .random_seed_i     (random_seed_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .selected_valid_o  (selected_valid_o),
    .selected_id_o     (selected_id_o),
    .won_lottery_o     (won_lottery_o)
  );

endmodule

`default_nettype wire

// ===== test/priority_task_selector_unit_tb.sv =====
`default_nettype none

module priority_task_selector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxTasks    = pts_pkg::MaxTasksDef;
  localparam int TimeBits    = pts_pkg::TimeBitsDef;
  localparam int IdW         = pts_pkg::IdWidth;
  localparam int PrioW       = pts_pkg::PrioWidth;
  localparam int TimeW       = pts_pkg::TimeWidth;
  localparam int LfsrW       = pts_pkg::LfsrWidth;
  localparam int DrainCycles = 40;    // longest close with a tie plus margin
  localparam int LongHold    = 200;   // receiver hold-off that backs up the input
  localparam int RandomItems = 1850;
  localparam logic [TimeW-1:0] TimeMask = TimeW'((64'd1 << TimeBits) - 1);

  typedef struct packed {
    logic             task_valid;
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
    logic [TimeW-1:0] arrival;
    logic [TimeW-1:0] duration;
    logic             running;
    logic             last;
  } cand_t;

  typedef struct packed {
    logic           found;
    logic [IdW-1:0] id;
    logic           lottery;
  } pick_t;

  typedef struct {
    cand_t cand;
    bit    known;
    pick_t pick;
  } dir_row_t;

  typedef enum int {RoundEmpty, RoundMixed, RoundTied, RoundFullTie} round_kind_e;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             task_valid_i;
  logic [IdW-1:0]   task_id_i;
  logic [PrioW-1:0] static_priority_i;
  logic [TimeW-1:0] arrival_time_i;
  logic [TimeW-1:0] total_duration_i;
  logic             is_running_i;
  logic             is_last_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             selected_valid_o;
  logic [IdW-1:0]   selected_id_o;
  logic             won_lottery_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [LfsrW-1:0] random_seed_i;

  priority_task_selector_unit #(
    .MAX_TASKS(MaxTasks),
    .TIME_BITS(TimeBits)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .task_valid_i     (task_valid_i),
    .task_id_i        (task_id_i),
    .static_priority_i(static_priority_i),
    .arrival_time_i   (arrival_time_i),
    .total_duration_i (total_duration_i),
    .is_running_i     (is_running_i),
    .is_last_i        (is_last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .selected_valid_o (selected_valid_o),
    .selected_id_o    (selected_id_o),
    .won_lottery_o    (won_lottery_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .random_seed_i    (random_seed_i)
  );

  // Scheduler state mirrored by the predictor
  bit             lead_valid;
  bit [PrioW-1:0] lead_prio;
  bit [TimeW-1:0] lead_arr;
  bit [TimeW-1:0] lead_dur;
  bit             lead_run;
  int unsigned    tie_cnt;
  bit [IdW-1:0]   tie_ids[MaxTasks];
  bit [LfsrW-1:0] lottery_lfsr;

  pick_t    pending_picks[$];
  dir_row_t directed_rows[$];
  int       mismatches;
  int       fed_items;
  bit       idling;
  bit       long_hold_req;

  // Fold one candidate into the round; return 1 with the selection on a close
  function automatic bit schedule_step(input cand_t c, output pick_t p);
    int             order;
    bit [TimeW-1:0] arr;
    bit [TimeW-1:0] dur;
    arr = c.arrival & TimeMask;
    dur = c.duration & TimeMask;
    p = '0;
    if (c.task_valid) begin
      if (!lead_valid) order = -1;
      else if (c.prio != lead_prio) order = (c.prio > lead_prio) ? -1 : 1;
      else if (c.running != lead_run) order = c.running ? -1 : 1;
      else if (arr != lead_arr) order = (arr < lead_arr) ? -1 : 1;
      else if (dur != lead_dur) order = (dur < lead_dur) ? -1 : 1;
      else order = 0;
      if (order < 0) begin
        lead_valid = 1;
        lead_prio  = c.prio;
        lead_arr   = arr;
        lead_dur   = dur;
        lead_run   = c.running;
        tie_ids[0] = c.id;
        tie_cnt    = 1;
      end else if (order == 0 && tie_cnt < MaxTasks) begin
        tie_ids[tie_cnt] = c.id;
        tie_cnt++;
      end
    end
    if (!c.last) return 0;
    p.found = lead_valid;
    if (lead_valid && tie_cnt > 1) begin
      // advance the Galois LFSR once, then draw among the tied ids
      if (lottery_lfsr[0]) lottery_lfsr = (lottery_lfsr >> 1) ^ pts_pkg::LfsrTaps;
      else lottery_lfsr = lottery_lfsr >> 1;
      p.id      = tie_ids[(lottery_lfsr % tie_cnt) % MaxTasks];
      p.lottery = 1;
    end else if (lead_valid) begin
      p.id = tie_ids[0];
    end
    lead_valid = 0;
    lead_prio  = '0;
    lead_arr   = '0;
    lead_dur   = '0;
    lead_run   = 0;
    tie_cnt    = 0;
    return 1;
  endfunction

  function automatic dir_row_t row(bit v, int id, int pr, int ar, int du, bit rn, bit ls,
                                   bit kn, bit f, int pid, bit lot);
    dir_row_t r;
    r.cand = '{task_valid: v, id: IdW'(id), prio: PrioW'(pr), arrival: TimeW'(ar),
               duration: TimeW'(du), running: rn, last: ls};
    r.known = kn;
    r.pick  = '{found: f, id: IdW'(pid), lottery: lot};
    return r;
  endfunction

  // Append one row to the directed table
  task automatic add_row(input dir_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endtask

  function automatic cand_t random_cand();
    cand_t c;
    c.task_valid = 1'($urandom_range(0, 1));
    c.id         = IdW'($urandom);
    c.prio       = PrioW'($urandom);
    c.arrival    = TimeW'($urandom);
    c.duration   = TimeW'($urandom);
    c.running    = 1'($urandom_range(0, 1));
    c.last       = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Offer one transaction, optionally after a gap, and predict once it is taken
  task automatic send_candidate(input cand_t c, input bit known, input pick_t typed);
    pick_t p;
    int    gap;
    if (idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i        <= 1'b1;
    task_valid_i      <= c.task_valid;
    task_id_i         <= c.id;
    static_priority_i <= c.prio;
    arrival_time_i    <= c.arrival;
    total_duration_i  <= c.duration;
    is_running_i      <= c.running;
    is_last_i         <= c.last;
    do @(posedge clk_i); while (in_stall_o);
    if (schedule_step(c, p)) pending_picks.insert(pending_picks.size(), known ? typed : p);
    fed_items++;
  endtask

  // Drop valid and wait until every selection has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_picks.size() == 0);
  endtask

  // Write the seed while the block is idle
  task automatic write_seed(input logic [LfsrW-1:0] seed);
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i   <= 1'b1;
    random_seed_i <= seed;
    do @(posedge clk_i); while (!cfg_ready_o);
    lottery_lfsr = (seed != '0) ? seed : pts_pkg::LfsrOne;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Generate whole rounds until the item count reaches the limit
  task automatic run_rounds(input int limit);
    round_kind_e        kind;
    int                 n;
    int                 r;
    cand_t              c;
    cand_t              base;
    bit                 closed;
    pick_t              none;
    none = '0;
    while (fed_items < limit) begin
      r = $urandom_range(0, 99);
      if (r < 8) kind = RoundEmpty;
      else if (r < 11) kind = RoundFullTie;
      else if (r < 55) kind = RoundTied;
      else kind = RoundMixed;
      case (kind)
        RoundEmpty:   n = 0;
        RoundFullTie: n = $urandom_range(MaxTasks + 1, MaxTasks + 8);
        default:      n = $urandom_range(1, 8);
      endcase
      base   = random_cand();
      closed = 0;
      for (int i = 0; i < n; i++) begin
        // sprinkle ignored transactions
        if ($urandom_range(0, 9) == 0) begin
          c      = random_cand();
          c.task_valid = 0;
          c.last = 0;
          send_candidate(c, 0, none);
        end
        c = random_cand();
        c.task_valid = 1;
        c.last       = 0;
        if (kind == RoundFullTie) begin
          c.prio     = base.prio;
          c.arrival  = base.arrival;
          c.duration = base.duration;
          c.running  = base.running;
        end else if (kind == RoundTied) begin
          if ($urandom_range(0, 3) != 0) c.prio = base.prio;
          if ($urandom_range(0, 3) != 0) c.arrival = base.arrival;
          if ($urandom_range(0, 3) != 0) c.duration = base.duration;
          if ($urandom_range(0, 3) != 0) c.running = base.running;
        end
        if (i == n - 1 && $urandom_range(0, 3) != 0) begin
          c.last = 1;
          closed = 1;
        end
        send_candidate(c, 0, none);
      end
      if (!closed) begin
        c = random_cand();
        c.task_valid = 0;
        c.last       = 1;
        send_candidate(c, 0, none);
      end
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int  hold_left;
    int  burst_left;
    bit  stall;
    hold_left   = 0;
    burst_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 0;
        hold_left     = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1;
      end else if (burst_left > 0) begin
        burst_left--;
        stall = 1;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(1, 5) - 1;
        stall      = 1;
      end else begin
        stall = 0;
      end
      out_stall_i <= stall;
    end
  end

  // Check each result transaction against the oldest pending selection
  always @(posedge clk_i) begin
    pick_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_picks.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual valid %0b id %0d lottery %0b",
                 $time, selected_valid_o, selected_id_o, won_lottery_o);
        mismatches++;
      end else begin
        want = pending_picks.pop_front();
        if (selected_valid_o !== want.found) begin
          $display("%0t: selected_valid expected %0b actual %0b",
                   $time, want.found, selected_valid_o);
          mismatches++;
        end
        if (selected_id_o !== want.id) begin
          $display("%0t: selected_id expected %0d actual %0d", $time, want.id, selected_id_o);
          mismatches++;
        end
        if (won_lottery_o !== want.lottery) begin
          $display("%0t: won_lottery expected %0b actual %0b",
                   $time, want.lottery, won_lottery_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus
  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    task_valid_i      = 1'b0;
    task_id_i         = '0;
    static_priority_i = '0;
    arrival_time_i    = '0;
    total_duration_i  = '0;
    is_running_i      = 1'b0;
    is_last_i         = 1'b0;
    cfg_valid_i       = 1'b0;
    random_seed_i     = '0;
    mismatches        = 0;
    fed_items         = 0;
    idling            = 1;
    long_hold_req     = 0;
    lead_valid        = 0;
    lead_prio         = '0;
    lead_arr          = '0;
    lead_dur          = '0;
    lead_run          = 0;
    tie_cnt           = 0;
    lottery_lfsr      = pts_pkg::LfsrOne;

    // Directed rounds: valid, id, prio, arrival, duration, running, last; expected
    // empty round
    add_row(row(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0));
    // ignored transaction, then a lone candidate at the field extremes
    add_row(row(0, 31, 255, 65535, 65535, 1, 0, 0, 0, 0, 0));
    add_row(row(1, 31, 255, 0, 65535, 1, 1, 1, 1, 31, 0));
    // higher priority wins, round closed by an invalid transaction
    add_row(row(1, 0, 0, 65535, 0, 0, 0, 0, 0, 0, 0));
    add_row(row(1, 5, 1, 65535, 65535, 0, 0, 0, 0, 0, 0));
    add_row(row(0, 0, 0, 0, 0, 0, 1, 1, 1, 5, 0));
    // running task keeps the processor
    add_row(row(1, 3, 10, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(row(1, 4, 10, 100, 100, 1, 1, 1, 1, 4, 0));
    // earlier arrival wins
    add_row(row(1, 6, 10, 50, 5, 0, 0, 0, 0, 0, 0));
    add_row(row(1, 7, 10, 40, 90, 0, 1, 1, 1, 7, 0));
    // shorter duration wins
    add_row(row(1, 8, 20, 7, 20, 0, 0, 0, 0, 0, 0));
    add_row(row(1, 9, 20, 7, 10, 0, 1, 1, 1, 9, 0));
    // two running candidates fall through to arrival
    add_row(row(1, 10, 30, 30, 1, 1, 0, 0, 0, 0, 0));
    add_row(row(1, 11, 30, 20, 1, 1, 0, 0, 0, 0, 0));
    add_row(row(1, 12, 29, 0, 0, 1, 1, 1, 1, 11, 0));
    // three-way tie decided by the lottery
    add_row(row(1, 13, 40, 3, 3, 0, 0, 0, 0, 0, 0));
    add_row(row(1, 14, 40, 3, 3, 0, 0, 0, 0, 0, 0));
    add_row(row(1, 15, 40, 3, 3, 0, 1, 0, 0, 0, 0));
    // a tie broken up by a better latecomer
    add_row(row(1, 16, 50, 1, 1, 0, 0, 0, 0, 0, 0));
    add_row(row(1, 17, 50, 1, 1, 0, 0, 0, 0, 0, 0));
    add_row(row(1, 18, 60, 9, 9, 0, 1, 1, 1, 18, 0));
    // tie formed after the leader changed
    add_row(row(1, 19, 5, 2, 2, 0, 0, 0, 0, 0, 0));
    add_row(row(1, 20, 6, 2, 2, 0, 0, 0, 0, 0, 0));
    add_row(row(1, 21, 6, 2, 2, 0, 1, 0, 0, 0, 0));
    // lowest priority alone still gets selected
    add_row(row(1, 0, 0, 65535, 65535, 0, 1, 1, 1, 0, 0));

    // Hold reset, then release between edges
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_candidate(directed_rows[i].cand, directed_rows[i].known, directed_rows[i].pick);

    // Random rounds over several seeds; zero seed falls back to one
    fed_items = 0;
    write_seed('0);
    run_rounds(RandomItems / 4);

    // All-ones seed; receiver holds off while rounds keep coming
    write_seed('1);
    long_hold_req = 1;
    run_rounds(RandomItems / 2);

    // Random seed; sender pauses midway until all selections are back
    write_seed($urandom);
    run_rounds(RandomItems * 5 / 8);
    drain_results();
    run_rounds(RandomItems * 3 / 4);

    // Random seed; last stretch runs without idling
    write_seed($urandom);
    run_rounds(RandomItems * 7 / 8);
    idling = 0;
    run_rounds(RandomItems);

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_picks.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/pts_pkg.sv
rtl/pts_ram.sv
rtl/pts_ctrl.sv
rtl/pts_datapath.sv
rtl/priority_task_selector_unit.sv
test/priority_task_selector_unit_tb.sv
